@@ hw/rtl/hlp_pkg.sv @@
// ----------------------------------------------------------------------------
// hlp_pkg
// Shared types and constants for the head layout permuter.
// ----------------------------------------------------------------------------
package hlp_pkg;

  localparam int CW      = 13;  // width of a size register and of the counters
  localparam int DATA_W  = 32;  // stream word width
  localparam int CFG_AW  = 5;   // register bank address width
  localparam int CFG_DW  = 32;  // register bank data width

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHAPE = 2'd1,
    STAT_PHASE = 2'd2
  } status_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_DRAIN = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    REG_KEY_HEADS  = 3'd0,
    REG_REPLICAS   = 3'd1,
    REG_HEAD_WIDTH = 3'd2,
    REG_ELEM_COUNT = 3'd3,
    REG_DIRECTION  = 3'd4
  } reg_idx_t;

  // Shape and control from the register bank to the datapath
  typedef struct packed {
    logic [CW-1:0] num_keys;
    logic [CW-1:0] replicas;
    logic [CW-1:0] lanes_per_head;
    logic [CW-1:0] element_count;
    logic          direction;
    logic          shape_ok;
    logic [CW-1:0] stride;     // outer size times head width
    logic          busy;       // shape products still settling
    logic          restart;    // a register write this cycle
  } cfg_t;

endpackage

@@ hw/rtl/hlp_cfg.sv @@
// ----------------------------------------------------------------------------
// hlp_cfg
// Register bank on the APB-style port plus the shape check pipeline.
// ----------------------------------------------------------------------------
module hlp_cfg #(
  parameter int DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hlp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [hlp_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [hlp_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output hlp_pkg::cfg_t               cfg
);
  import hlp_pkg::*;

  localparam int NW = 3 * CW;
  localparam logic [1:0] SETTLE = 2'd3;

  logic [CW-1:0]   key_r, key_nxt;
  logic [CW-1:0]   rep_r, rep_nxt;
  logic [CW-1:0]   wid_r, wid_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            dir_r, dir_nxt;
  logic [1:0]      settle_r, settle_nxt;
  logic [2*CW-1:0] kr_r;
  logic [2*CW-1:0] stride_r;
  logic [NW-1:0]   n_r;
  logic            ok_r;
  logic            wr;
  logic            hit;
  reg_idx_t        idx;

  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    key_nxt = key_r;
    rep_nxt = rep_r;
    wid_nxt = wid_r;
    cnt_nxt = cnt_r;
    dir_nxt = dir_r;
    hit     = 1'b0;
    if (wr) begin
      hit = 1'b1;
      case (idx)
        REG_KEY_HEADS:  key_nxt = cfg_pwdata[CW-1:0];
        REG_REPLICAS:   rep_nxt = cfg_pwdata[CW-1:0];
        REG_HEAD_WIDTH: wid_nxt = cfg_pwdata[CW-1:0];
        REG_ELEM_COUNT: cnt_nxt = cfg_pwdata[CW-1:0];
        REG_DIRECTION:  dir_nxt = cfg_pwdata[0];
        default:        hit = 1'b0;
      endcase
    end
    settle_nxt = hit ? SETTLE : ((settle_r != 2'd0) ? settle_r - 2'd1 : settle_r);
  end

  always_comb begin
    case (idx)
      REG_KEY_HEADS:  cfg_prdata = CFG_DW'(key_r);
      REG_REPLICAS:   cfg_prdata = CFG_DW'(rep_r);
      REG_HEAD_WIDTH: cfg_prdata = CFG_DW'(wid_r);
      REG_ELEM_COUNT: cfg_prdata = CFG_DW'(cnt_r);
      REG_DIRECTION:  cfg_prdata = CFG_DW'(dir_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= CW'(1);
      rep_r    <= CW'(1);
      wid_r    <= CW'(1);
      cnt_r    <= CW'(1);
      dir_r    <= 1'b0;
      settle_r <= SETTLE;
    end else begin
      key_r    <= key_nxt;
      rep_r    <= rep_nxt;
      wid_r    <= wid_nxt;
      cnt_r    <= cnt_nxt;
      dir_r    <= dir_nxt;
      settle_r <= settle_nxt;
    end
  end

  // Shape products: key times replicas and the stride, then the block size, then the compare
  always_ff @(posedge clk) begin
    kr_r     <= key_r * rep_r;
    stride_r <= (dir_r ? key_r : rep_r) * wid_r;
    n_r      <= kr_r * wid_r;
    ok_r     <= (key_r != '0) && (rep_r != '0) && (wid_r != '0) &&
                (n_r == NW'(cnt_r)) && (n_r <= NW'(DEPTH));
  end

  always_comb begin
    cfg.num_keys       = key_r;
    cfg.replicas       = rep_r;
    cfg.lanes_per_head = wid_r;
    cfg.element_count  = cnt_r;
    cfg.direction      = dir_r;
    cfg.shape_ok       = ok_r;
    cfg.stride         = stride_r[CW-1:0];
    cfg.busy           = (settle_r != 2'd0);
    cfg.restart        = hit;
  end

endmodule

@@ hw/rtl/hlp_store.sv @@
// ----------------------------------------------------------------------------
// hlp_store
// Block buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hlp_store #(
  parameter int DEPTH     = 4096,
  parameter int WORD_BITS = 32,
  parameter int AW        = 12
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/head_layout_permuter.sv @@
// ----------------------------------------------------------------------------
// head_layout_permuter
// Loads a block in tiled or grouped order and drains it in the other order.
// Throughput: one request per cycle while out_tready is high and the shape
// products are not settling. A drain or error result is registered at
// acceptance (drain data by the buffer's registered read) and again in the
// output register; a good load gives no result. After reset and after every
// register write, in_tready is held low while the shape products settle.
// Reset (rst_n, synchronous): counters clear, loading phase; buffer kept.
// ----------------------------------------------------------------------------
module head_layout_permuter #(
  parameter int DEPTH     = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [hlp_pkg::DATA_W-1:0]   in_tdata,   // [31:0] data_word
  input  logic                         in_tuser,   // [0] mode
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [hlp_pkg::DATA_W-1:0]   out_tdata,  // [31:0] out_word
  output logic                         out_tlast,  // last_word
  output logic [1:0]                   out_tuser,  // [1:0] status
  // register port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [hlp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [hlp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [hlp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import hlp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  logic [CW-1:0] lane_r, lane_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] outer_r, outer_nxt;
  logic [CW-1:0] obase_r, obase_nxt;
  logic [CW-1:0] mbase_r, mbase_nxt;
  logic [CW-1:0] rp_r, rp_nxt;
  logic          full_r, full_nxt;

  logic          p1_v_r, p1_v_nxt;
  logic          p1_rd_r, p1_rd_nxt;
  logic          p1_last_r, p1_last_nxt;
  status_t       p1_stat_r, p1_stat_nxt;

  logic              out_v_r;
  logic [DATA_W-1:0] out_word_r;
  logic              out_last_r;
  status_t           out_stat_r;

  logic          accept;
  logic          p1_move;
  mode_t         mode;
  logic [CW-1:0] osize, msize;
  logic [CW-1:0] waddr;
  logic          we, re;
  logic [WORD_BITS-1:0] rdata;

  hlp_cfg #(.DEPTH(DEPTH)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hlp_store #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(waddr)),
    .wdata (WORD_BITS'(in_tdata)),
    .re    (re),
    .raddr (AW'(rp_r)),
    .rdata (rdata)
  );

  assign p1_move   = !out_v_r || out_tready;
  assign in_tready = !cfg.busy && (!p1_v_r || p1_move);
  assign accept    = in_tvalid && in_tready;
  assign mode      = mode_t'(in_tuser);
  assign osize     = cfg.direction ? cfg.num_keys : cfg.replicas;
  assign msize     = cfg.direction ? cfg.replicas : cfg.num_keys;
  // destination address: outer*W + middle*stride + lane
  assign waddr     = obase_r + mbase_r + lane_r;

  always_comb begin
    lane_nxt    = lane_r;
    mid_nxt     = mid_r;
    outer_nxt   = outer_r;
    obase_nxt   = obase_r;
    mbase_nxt   = mbase_r;
    rp_nxt      = rp_r;
    full_nxt    = full_r;
    we          = 1'b0;
    re          = 1'b0;
    p1_rd_nxt   = p1_rd_r;
    p1_last_nxt = p1_last_r;
    p1_stat_nxt = p1_stat_r;
    p1_v_nxt    = p1_v_r && !p1_move;

    if (accept) begin
      p1_v_nxt    = 1'b1;
      p1_rd_nxt   = 1'b0;
      p1_last_nxt = 1'b0;
      p1_stat_nxt = STAT_OK;
      if (!cfg.shape_ok) begin
        p1_stat_nxt = STAT_SHAPE;
      end else if (mode == MODE_LOAD) begin
        if (full_r) begin
          p1_stat_nxt = STAT_PHASE;
        end else begin
          p1_v_nxt = 1'b0;
          we       = 1'b1;
          lane_nxt = lane_r + CW'(1);
          if (lane_r + CW'(1) == cfg.lanes_per_head) begin
            lane_nxt  = '0;
            mid_nxt   = mid_r + CW'(1);
            mbase_nxt = mbase_r + cfg.stride;
            if (mid_r + CW'(1) == msize) begin
              mid_nxt   = '0;
              mbase_nxt = '0;
              outer_nxt = outer_r + CW'(1);
              obase_nxt = obase_r + cfg.lanes_per_head;
              if (outer_r + CW'(1) == osize) begin
                outer_nxt = '0;
                obase_nxt = '0;
                rp_nxt    = '0;
                full_nxt  = 1'b1;
              end
            end
          end
        end
      end else begin
        if (!full_r) begin
          p1_stat_nxt = STAT_PHASE;
        end else begin
          re        = 1'b1;
          p1_rd_nxt = 1'b1;
          if (rp_r + CW'(1) == cfg.element_count) begin
            // final word: hand the block back to loading
            p1_last_nxt = 1'b1;
            rp_nxt      = '0;
            full_nxt    = 1'b0;
          end else begin
            rp_nxt = rp_r + CW'(1);
          end
        end
      end
    end

    if (cfg.restart) begin
      lane_nxt  = '0;
      mid_nxt   = '0;
      outer_nxt = '0;
      obase_nxt = '0;
      mbase_nxt = '0;
      rp_nxt    = '0;
      full_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r  <= '0;
      mid_r   <= '0;
      outer_r <= '0;
      obase_r <= '0;
      mbase_r <= '0;
      rp_r    <= '0;
      full_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      lane_r  <= lane_nxt;
      mid_r   <= mid_nxt;
      outer_r <= outer_nxt;
      obase_r <= obase_nxt;
      mbase_r <= mbase_nxt;
      rp_r    <= rp_nxt;
      full_r  <= full_nxt;
      p1_v_r  <= p1_v_nxt;
      if (p1_move) begin
        out_v_r <= p1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_rd_r   <= p1_rd_nxt;
    p1_last_r <= p1_last_nxt;
    p1_stat_r <= p1_stat_nxt;
    // read data holds while the stage waits, since no new read is issued
    if (p1_move) begin
      out_word_r <= p1_rd_r ? DATA_W'(rdata) : '0;
      out_last_r <= p1_last_r;
      out_stat_r <= p1_stat_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

endmodule

@@ tb/layout_shadow_pkg.sv @@
// ----------------------------------------------------------------------------
// layout_shadow_pkg
// Tracks the permuter's block buffer, counters and shape registers, predicts
// the result of every accepted request that gives one and checks the block's
// results against them in order.
// ----------------------------------------------------------------------------
package layout_shadow_pkg;

  import hlp_pkg::*;

  localparam int STORE_WORDS = 4096;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              last;
    status_t           status;
  } drained_t;

  class layout_shadow;

    drained_t          awaited_results[$];
    logic [DATA_W-1:0] block_words[STORE_WORDS];

    // shape registers as the block holds them
    logic [CW-1:0] num_keys;
    logic [CW-1:0] replicas;
    logic [CW-1:0] lanes_per_head;
    logic [CW-1:0] elem_count;
    logic          direction;

    int unsigned outer_pos;
    int unsigned middle_pos;
    int unsigned lane_pos;
    int unsigned read_pos;
    bit          loaded;

    int mismatches;
    int results_seen;
    int blocks_drained;

    function new();
      num_keys       = 1;
      replicas       = 1;
      lanes_per_head = 1;
      elem_count     = 1;
      direction      = 1'b0;
      mismatches = 0;
      results_seen = 0;
      blocks_drained = 0;
      restart();
    endfunction

    function void restart();
      outer_pos  = 0;
      middle_pos = 0;
      lane_pos   = 0;
      read_pos   = 0;
      loaded     = 1'b0;
    endfunction

    function void apply_register(reg_idx_t idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_KEY_HEADS:  num_keys       = value[CW-1:0];
        REG_REPLICAS:   replicas       = value[CW-1:0];
        REG_HEAD_WIDTH: lanes_per_head = value[CW-1:0];
        REG_ELEM_COUNT: elem_count     = value[CW-1:0];
        REG_DIRECTION:  direction      = value[0];
        default: return;
      endcase
      restart();
    endfunction

    function longint block_words_needed();
      return longint'(num_keys) * longint'(replicas) * longint'(lanes_per_head);
    endfunction

    function bit shape_valid();
      longint n;
      if (num_keys == 0 || replicas == 0 || lanes_per_head == 0) return 1'b0;
      n = block_words_needed();
      return n == longint'(elem_count) && n <= STORE_WORDS;
    endfunction

    function void await_result(logic [DATA_W-1:0] word, logic last, status_t status);
      drained_t r;
      r.word   = word;
      r.last   = last;
      r.status = status;
      awaited_results.push_back(r);
    endfunction

    function void absorb_request(mode_t mode, logic [DATA_W-1:0] data);
      longint      n;
      longint      addr;
      int unsigned outer_size;
      int unsigned middle_size;
      bit          last;
      if (!shape_valid()) begin
        await_result('0, 1'b0, STAT_SHAPE);
        return;
      end
      n = block_words_needed();
      if (mode == MODE_LOAD) begin
        if (loaded) begin
          await_result('0, 1'b0, STAT_PHASE);
          return;
        end
        // tiled source walks replica then key; grouped source walks key then replica
        if (direction == 1'b0) begin
          outer_size  = replicas;
          middle_size = num_keys;
          addr = (longint'(middle_pos) * replicas + outer_pos) * lanes_per_head + lane_pos;
        end else begin
          outer_size  = num_keys;
          middle_size = replicas;
          addr = (longint'(middle_pos) * num_keys + outer_pos) * lanes_per_head + lane_pos;
        end
        if (addr < STORE_WORDS) block_words[addr] = data;
        lane_pos++;
        if (lane_pos >= lanes_per_head) begin
          lane_pos = 0;
          middle_pos++;
          if (middle_pos >= middle_size) begin
            middle_pos = 0;
            outer_pos++;
            if (outer_pos >= outer_size) begin
              outer_pos = 0;
              read_pos  = 0;
              loaded    = 1'b1;
            end
          end
        end
      end else begin
        if (!loaded) begin
          await_result('0, 1'b0, STAT_PHASE);
          return;
        end
        last = (longint'(read_pos) + 1 >= n);
        await_result(block_words[read_pos], last, STAT_OK);
        if (last) begin
          restart();
          blocks_drained++;
        end else begin
          read_pos++;
        end
      end
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task match_result(logic [DATA_W-1:0] word, logic last, logic [1:0] status);
      drained_t exp;
      results_seen++;
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: word %08h last %0b status %0d",
                                word, last, status));
        return;
      end
      exp = awaited_results.pop_front();
      if (status !== exp.status)
        flag_mismatch($sformatf("status %0d, wanted %0d", status, exp.status));
      if (word !== exp.word)
        flag_mismatch($sformatf("word %08h, wanted %08h", word, exp.word));
      if (last !== exp.last)
        flag_mismatch($sformatf("last %0b, wanted %0b", last, exp.last));
    endtask

  endclass

endpackage

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Streams load and drain requests through head_layout_permuter under many
// shapes and both directions, with random stalls on both streams, and checks
// every result against a shadow of the block's buffer and counters.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import hlp_pkg::*;
  import layout_shadow_pkg::*;

  localparam int ITEM_GOAL   = 1700;
  localparam int FINAL_ITEMS = 512;
  localparam int CYCLE_CAP   = 400000;
  localparam int IDLE_PCT    = 32;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic                out_tlast;
  logic [1:0]          out_tuser;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  layout_shadow sb;
  int  items_sent = 0;
  int  reg_writes = 0;
  int  shapes_valid = 0;
  int  shapes_bad = 0;
  int  calm_from = 0;
  int  calm_to = 0;
  bit  steady = 1'b0;
  int  cycles = 0;

  head_layout_permuter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random back-pressure, check every accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_tvalid && out_tready)
        sb.match_result(out_tdata, out_tlast, out_tuser);
    end
  end

  task automatic push_request(mode_t mode, logic [DATA_W-1:0] data);
    steady = (items_sent >= calm_from) && (items_sent < calm_to);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    sb.absorb_request(mode, data);
    items_sent++;
  endtask

  // drop valid, drain pending results, then give loads in flight time to land
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [CW-1:0] value);
    logic [CFG_DW-1:0] readback;
    readback = (idx == REG_DIRECTION) ? CFG_DW'(value[0]) : CFG_DW'(value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.apply_register(idx, CFG_DW'(value));
    reg_writes++;
    // read it straight back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== readback)
      sb.flag_mismatch($sformatf("register %0d reads %08h, wanted %08h",
                                 idx, cfg_prdata, readback));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_shape(int unsigned kh, int unsigned rp, int unsigned hw,
                               int unsigned ec, bit dir);
    settle_idle();
    write_register(REG_KEY_HEADS,  CW'(kh));
    write_register(REG_REPLICAS,   CW'(rp));
    write_register(REG_HEAD_WIDTH, CW'(hw));
    write_register(REG_ELEM_COUNT, CW'(ec));
    write_register(REG_DIRECTION,  CW'(dir));
    if (sb.shape_valid()) shapes_valid++;
    else shapes_bad++;
  endtask

  task automatic random_noise(int count);
    repeat (count) push_request(mode_t'($urandom_range(0, 1)), $urandom());
  endtask

  // blocks of load then drain, optionally with wrong-phase strays and a cut last block
  task automatic run_blocks(int blocks, bit allow_cut);
    int n;
    int cut;
    n = int'(sb.block_words_needed());
    for (int b = 0; b < blocks; b++) begin
      cut = 2 * n;
      if (allow_cut && b == blocks - 1 && $urandom_range(0, 5) == 0)
        cut = $urandom_range(0, 2 * n - 1);
      for (int j = 0; j < cut; j++) begin
        if (j < n) begin
          if (allow_cut && $urandom_range(0, 9) == 0) push_request(MODE_DRAIN, $urandom());
          push_request(MODE_LOAD, $urandom());
        end else begin
          if (allow_cut && $urandom_range(0, 9) == 0) push_request(MODE_LOAD, $urandom());
          push_request(MODE_DRAIN, $urandom());
        end
      end
    end
  endtask

  task automatic run_random_phase();
    int unsigned kh;
    int unsigned rp;
    int unsigned hw;
    int unsigned n;
    int          pick;
    pick = $urandom_range(0, 9);
    kh = $urandom_range(1, 4);
    rp = $urandom_range(1, 4);
    hw = $urandom_range(1, 8);
    n  = kh * rp * hw;
    case (pick)
      0: begin
        case ($urandom_range(0, 2))
          0: kh = 0;
          1: rp = 0;
          default: hw = 0;
        endcase
        program_shape(kh, rp, hw, $urandom_range(0, 64), $urandom_range(0, 1));
        random_noise($urandom_range(6, 16));
      end
      1: begin
        program_shape(kh, rp, hw, $urandom_range(0, 1) ? n + 1 : n - 1, $urandom_range(0, 1));
        random_noise($urandom_range(6, 16));
      end
      2: begin
        // products beyond the buffer, some whose low 13 bits match the programmed count
        case ($urandom_range(0, 3))
          0: program_shape(4096, 4096, 4096, 0, $urandom_range(0, 1));
          1: program_shape(4096, 2, 1, 0, $urandom_range(0, 1));
          2: program_shape(64, 64, 2, 4096, $urandom_range(0, 1));
          default: program_shape($urandom_range(65, 4096), $urandom_range(65, 4096),
                                 $urandom_range(1, 4096), $urandom_range(0, 4096),
                                 $urandom_range(0, 1));
        endcase
        random_noise($urandom_range(6, 16));
      end
      default: begin
        program_shape(kh, rp, hw, n, $urandom_range(0, 1));
        run_blocks($urandom_range(1, 3), 1'b1);
      end
    endcase
  endtask

  initial begin
    int random_start;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape is a single word
    push_request(MODE_DRAIN, 32'h0000_0000);
    push_request(MODE_LOAD,  32'h0000_0000);
    push_request(MODE_LOAD,  32'h5555_5555);
    push_request(MODE_DRAIN, 32'hFFFF_FFFF);
    push_request(MODE_LOAD,  32'hFFFF_FFFF);
    push_request(MODE_DRAIN, 32'h0000_0000);
    for (int d = 0; d < 2; d++) begin
      program_shape(2, 2, 1, 4, d[0]);
      for (int i = 0; i < 4; i++) push_request(MODE_LOAD, 32'hA5A5_0000 + i);
      for (int i = 0; i < 4; i++) push_request(MODE_DRAIN, 32'h0);
    end
    program_shape(0, 1, 1, 0, 1'b0);
    push_request(MODE_LOAD,  32'hAAAA_AAAA);
    push_request(MODE_DRAIN, 32'h0);

    random_start = items_sent;
    calm_from = random_start + 400;
    calm_to   = random_start + 800;
    while (items_sent < ITEM_GOAL - FINAL_ITEMS) run_random_phase();

    // one larger block to close, each shape 256 words
    case ($urandom_range(0, 3))
      0: program_shape(256, 1, 1, 256, $urandom_range(0, 1));
      1: program_shape(1, 256, 1, 256, $urandom_range(0, 1));
      2: program_shape(1, 1, 256, 256, $urandom_range(0, 1));
      default: program_shape(8, 8, 4, 256, $urandom_range(0, 1));
    endcase
    run_blocks(1, 1'b0);

    settle_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d register writes, %0d blocks drained",
             items_sent, sb.results_seen, reg_writes, sb.blocks_drained);
    $display("shapes programmed: %0d accepted, %0d rejected", shapes_valid, shapes_bad);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
